@@ rtl/core/fvesg_pkg.sv @@
package fvesg_pkg;

    localparam int NumVoicesDefault = 4;
    localparam int RomSize = 208;
    localparam logic [2:0] NoVoice = 3'd4;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_FRAME  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam int CfgEnabled  = 0;
    localparam int CfgTestTone = 1;

    // (125000 << 32) / 44100
    localparam logic [63:0] StepK = (64'd125000 << 32) / 64'd44100;
    localparam logic [31:0] ToneStep = 32'((64'd440 << 32) / 64'd44100);

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] duration;
        logic [7:0] offset;
        logic [7:0] stage_left;
        logic [7:0] loops;
        logic [7:0] loop_at;
    } t_env;

    // one classified item handed from front to back
    typedef struct packed {
        t_op        op;
        logic       prio;
        logic [7:0] vol_start;
        logic [7:0] vol_byte;
        logic [7:0] pit_start;
        logic [7:0] pit_byte;
        logic       drop;
        logic [7:0] atten;
    } t_cmd;

    function automatic logic [7:0] rom_at(input logic [7:0] idx);
        logic [7:0] rom [RomSize];
        rom = '{
        8'h88,8'h03,8'h10,8'h03,8'hf0,8'h80,8'h03,8'hc0,8'h01,8'h04,8'h05,8'h06,8'h82,8'h0c,8'hfe,8'h03,
        8'h03,8'h80,8'h01,8'hf9,8'h02,8'h01,8'h02,8'hff,8'h08,8'hf0,8'h08,8'hf8,8'h01,8'hfb,8'h87,8'h03,
        8'ha1,8'h03,8'h81,8'h80,8'h83,8'h02,8'ha3,8'h02,8'h81,8'h80,8'h3e,8'h00,8'h01,8'h06,8'h0a,8'h0c,
        8'h0a,8'h00,8'h78,8'hfe,8'h0f,8'h10,8'h0f,8'hf4,8'hf8,8'h04,8'h02,8'h05,8'hfe,8'h80,8'h08,8'hf0,
        8'h0a,8'hf8,8'h0c,8'hfc,8'h92,8'h03,8'h02,8'h03,8'h01,8'h03,8'h00,8'h03,8'hff,8'h03,8'hfe,8'h80,
        8'h03,8'h03,8'h03,8'h01,8'h03,8'h00,8'h0c,8'hff,8'h04,8'h20,8'h05,8'h10,8'h05,8'h08,8'h04,8'he0,
        8'h05,8'hf0,8'h05,8'hf8,8'he1,8'h01,8'hf8,8'h08,8'h01,8'he1,8'h01,8'h1a,8'h0d,8'hfe,8'h80,8'h01,
        8'h18,8'h64,8'h00,8'h88,8'h02,8'h00,8'h01,8'h40,8'h02,8'h00,8'h01,8'hbc,8'h90,8'h03,8'h00,8'h01,
        8'h0c,8'h03,8'h00,8'h01,8'hf4,8'h80,8'h10,8'h00,8'h01,8'h2f,8'h10,8'h00,8'h01,8'hf9,8'h10,8'h00,
        8'h01,8'hf1,8'h83,8'h10,8'hf0,8'h87,8'h04,8'h20,8'h02,8'hfd,8'h02,8'hc0,8'h80,8'h0b,8'h14,8'h83,
        8'h03,8'hf0,8'h03,8'h10,8'h80,8'h03,8'hbc,8'h07,8'h06,8'h82,8'h02,8'hfe,8'h04,8'h02,8'h80,8'h11,
        8'hff,8'h0b,8'h14,8'h01,8'h02,8'h02,8'h83,8'h0a,8'h03,8'h04,8'h09,8'h88,8'h01,8'h0b,8'h01,8'he0,
        8'h01,8'h15,8'hac,8'h01,8'h14,8'h01,8'hec,8'h80,8'h10,8'hff,8'h14,8'hf8,8'h28,8'h02,8'h01,8'h00
        };
        if (idx < 8'(RomSize)) begin
            return rom[idx];
        end
        return 8'h00;
    endfunction

    // range select over the limit table
    function automatic logic [1:0] range_sel(input logic [7:0] a);
        if (a >= 8'hb6) return 2'd3;
        if (a >= 8'h84) return 2'd2;
        if (a >= 8'h40) return 2'd1;
        return 2'd0;
    endfunction

    function automatic logic [7:0] base_of(input logic [1:0] y);
        logic [7:0] r;
        unique case (y)
            2'd0: r = 8'he0;
            2'd1: r = 8'h10;
            2'd2: r = 8'h4a;
            default: r = 8'h80;
        endcase
        return r;
    endfunction

    // divisor of the square step for a pitch value (never zero)
    function automatic logic [10:0] step_div(input logic [7:0] b);
        logic [7:0]  a;
        logic [1:0]  y;
        logic [10:0] n;
        a = b ^ 8'hff;
        y = range_sel(a);
        n = 11'(8'(a - base_of(y))) << y;
        if (n == 11'd0) n = 11'd1;
        return n;
    endfunction

    function automatic logic [7:0] noise_reg_for(input logic [7:0] b);
        logic [7:0] a;
        logic [1:0] y;
        a = b ^ 8'hff;
        y = range_sel(a);
        a = 8'(a - base_of(y));
        a = 8'(a << y);
        return (a & 8'h0f) | 8'he0;
    endfunction

    function automatic logic [31:0] noise_step(input logic [1:0] sel);
        logic [31:0] r;
        unique case (sel)
            2'd0: r = 32'((64'd7813 << 32) / 64'd44100);
            2'd1: r = 32'((64'd3906 << 32) / 64'd44100);
            default: r = 32'((64'd1953 << 32) / 64'd44100);
        endcase
        return r;
    endfunction

    // one frame of envelope stepping; returns advanced flag in adv
    function automatic t_env env_advance(input t_env ei, output logic adv);
        t_env       e;
        logic [7:0] y;
        logic [7:0] b;
        logic       done;
        e = ei;
        adv = 1'b0;
        done = 1'b0;
        if (e.duration == 8'd0) begin
            done = 1'b1;
        end else if (e.stage_left == 8'd0) begin
            if (e.loops == 8'd0) begin
                e.duration = e.duration - 8'd1;
                if (e.duration == 8'd0) done = 1'b1;
            end
            if (!done) begin
                y = e.offset + 8'd1;
                b = rom_at(y);
                if (b[7]) begin
                    if (e.loops == 8'd0) begin
                        e.loops = b & 8'h7f;
                        y = y + 8'd1;
                        e.loop_at = y;
                    end else begin
                        e.loops = e.loops - 8'd1;
                    end
                    y = e.loop_at;
                    b = rom_at(y);
                end
                e.stage_left = b;
                e.offset = y + 8'd1;
            end
        end
        if (!done) begin
            e.value = e.value + rom_at(e.offset);
            e.stage_left = e.stage_left - 8'd1;
            adv = 1'b1;
        end
        return e;
    endfunction

endpackage

@@ rtl/core/four_voice_envelope_sound_generator.sv @@
// A start runs the voice pick and the pitch step divide; a frame tick steps each active
// voice and divides for each pitch step update; a sample tick mixes each audible voice.
// Throughput: one item at a time in the back end, set by the voice sequencer
// and the bit-serial divider; a two-entry queue decouples input acceptance.
// Reset (synchronous, active low): all voices silent, enabled=1, test_tone=0.
module four_voice_envelope_sound_generator #(
    parameter int NUM_VOICES = fvesg_pkg::NumVoicesDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_op,
    input  logic              i_hint_priority,
    input  logic [7:0]        i_volume_env_start,
    input  logic [7:0]        i_volume_byte,
    input  logic [7:0]        i_pitch_env_start,
    input  logic [7:0]        i_pitch_byte,
    input  logic              i_positioned,
    input  logic [7:0]        i_source_x,
    input  logic [7:0]        i_source_y,
    input  logic [7:0]        i_listener_x,
    input  logic [7:0]        i_listener_y,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [6:0] o_sample,
    output logic [2:0]        o_loaded_voice,
    output logic [3:0]        o_busy_mask,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [0:0]        i_cfg_index,
    input  logic [0:0]        i_cfg_data
);
    logic r_enabled, r_test_tone;
    logic cmd_valid, cmd_ready;
    fvesg_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
            r_test_tone <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'(fvesg_pkg::CfgEnabled)) r_enabled <= i_cfg_data;
            else r_test_tone <= i_cfg_data;
        end
    end

    fvesg_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op, .i_hint_priority,
        .i_volume_env_start, .i_volume_byte, .i_pitch_env_start, .i_pitch_byte,
        .i_positioned, .i_source_x, .i_source_y, .i_listener_x, .i_listener_y,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    fvesg_back #(.NUM_VOICES(NUM_VOICES)) u_back (
        .i_clk, .i_rst_n, .i_enabled(r_enabled), .i_test_tone(r_test_tone),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_sample, .o_loaded_voice, .o_busy_mask
    );
endmodule

@@ rtl/core/fvesg_front.sv @@
module fvesg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic                 i_hint_priority,
    input  logic [7:0]           i_volume_env_start,
    input  logic [7:0]           i_volume_byte,
    input  logic [7:0]           i_pitch_env_start,
    input  logic [7:0]           i_pitch_byte,
    input  logic                 i_positioned,
    input  logic [7:0]           i_source_x,
    input  logic [7:0]           i_source_y,
    input  logic [7:0]           i_listener_x,
    input  logic [7:0]           i_listener_y,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output fvesg_pkg::t_cmd      o_cmd
);
    localparam int PtrW = $clog2(fvesg_pkg::QueueDepth);

    fvesg_pkg::t_cmd r_q [fvesg_pkg::QueueDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_cnt;
    fvesg_pkg::t_cmd cmd;
    logic [7:0] dx, dy, ax, ay, cheb;
    logic push, pop;

    // classify: distance gate and attenuation
    always_comb begin
        dx = i_source_x - i_listener_x;
        dy = i_source_y - i_listener_y;
        ax = dx[7] ? 8'(-dx) : dx;
        ay = dy[7] ? 8'(-dy) : dy;
        cheb = (ax > ay) ? ax : ay;
        cmd.op = fvesg_pkg::t_op'(i_op);
        cmd.prio = i_hint_priority;
        cmd.vol_start = i_volume_env_start;
        cmd.vol_byte = i_volume_byte;
        cmd.pit_start = i_pitch_env_start;
        cmd.pit_byte = i_pitch_byte;
        cmd.drop = i_positioned && (cheb >= 8'd16);
        cmd.atten = i_positioned ? 8'(cheb << 4) : 8'd0;
    end

    assign o_ready = (r_cnt != (PtrW+1)'(fvesg_pkg::QueueDepth));
    assign push = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop = o_cmd_valid && i_cmd_ready;
    assign o_cmd = r_q[r_rp];

    // command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd;
    end
endmodule

@@ rtl/core/fvesg_back.sv @@
module fvesg_back #(
    parameter int NUM_VOICES = fvesg_pkg::NumVoicesDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_enabled,
    input  logic                 i_test_tone,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  fvesg_pkg::t_cmd      i_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [6:0]    o_sample,
    output logic [2:0]           o_loaded_voice,
    output logic [3:0]           o_busy_mask
);
    localparam int VW = $clog2(NUM_VOICES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_VOICE = 6'b000010,
        S_DIV   = 6'b000100,
        S_FIN   = 6'b001000,
        S_OUT   = 6'b010000,
        S_PICK  = 6'b100000
    } t_state;

    t_state r_state;
    fvesg_pkg::t_cmd r_cmd;
    fvesg_pkg::t_env r_ve [NUM_VOICES];
    fvesg_pkg::t_env r_pe [NUM_VOICES];
    logic [31:0] r_phase [NUM_VOICES];
    logic [31:0] r_step [NUM_VOICES];
    logic [7:0]  r_att [NUM_VOICES];
    logic [14:0] r_nshift;
    logic [31:0] r_nacc;
    logic [31:0] r_tone;
    logic [VW-1:0] r_vi;
    logic signed [9:0] r_mix;
    logic [2:0] r_loaded;
    logic [VW-1:0] r_dv;
    // restoring divider: StepK / divisor
    logic [63:0] r_quo;
    logic [11:0] r_rem;
    logic [10:0] r_den;
    logic [5:0]  r_bit;
    logic r_div_go;

    fvesg_pkg::t_env ve_n, pe_n, ve_f;
    logic vadv, padv;
    logic [11:0] rem_sh;
    logic [VW-1:0] pick;
    logic [VW:0] i;
    logic start_ok, frame_act, voice_last;
    logic signed [9:0] tone_mix;

    assign o_cmd_ready = (r_state == S_IDLE);

    // voice pick: lowest idle from 1, else quietest from 1; the priority hint takes voice 0
    always_comb begin
        logic found;
        logic [7:0] qv;
        found = 1'b0;
        pick = VW'(1);
        qv = r_ve[1].value;
        for (i = 1; i < (VW+1)'(NUM_VOICES); i++) begin
            if (!found && r_ve[i[VW-1:0]].duration == 8'd0) begin
                found = 1'b1;
                pick = i[VW-1:0];
            end
        end
        if (!found) begin
            for (i = 2; i < (VW+1)'(NUM_VOICES); i++) begin
                if (r_ve[i[VW-1:0]].value < qv) begin
                    pick = i[VW-1:0];
                    qv = r_ve[i[VW-1:0]].value;
                end
            end
        end
        if (r_cmd.prio) pick = '0;
    end

    // envelope step for the current voice, start gate, tone term
    always_comb begin
        ve_n = fvesg_pkg::env_advance(r_ve[r_vi], vadv);
        pe_n = fvesg_pkg::env_advance(r_pe[r_vi], padv);
        ve_f = ve_n;
        // ended volume fades by 4 per frame
        if (!vadv) ve_f.value = (ve_n.value > 8'd4) ? ve_n.value - 8'd4 : 8'd0;
        rem_sh = {r_rem[10:0], r_quo[63]};
        start_ok = i_enabled && !r_cmd.drop &&
            !(r_ve[pick].duration != 8'd0 &&
              (r_cmd.vol_byte & 8'hf0) < r_ve[pick].value);
        frame_act = (r_cmd.op == fvesg_pkg::OP_FRAME) &&
            (r_ve[r_vi].value[7:4] != 4'd0 || r_ve[r_vi].duration != 8'd0);
        voice_last = (r_vi == VW'(NUM_VOICES - 1));
        tone_mix = (i_test_tone && i_cmd.op == fvesg_pkg::OP_SAMPLE) ?
            (r_tone[31] ? 10'sd30 : -10'sd30) : 10'sd0;
    end

    // sequencer over voices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_div_go <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 0; k < NUM_VOICES; k++) begin
                r_ve[k] <= '0;
                r_pe[k] <= '0;
                r_phase[k] <= '0;
                r_step[k] <= '0;
                r_att[k] <= '0;
            end
            r_nshift <= '0;
            r_nacc <= '0;
            r_tone <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_vi <= '0;
                        r_mix <= tone_mix;
                        r_loaded <= fvesg_pkg::NoVoice;
                        r_div_go <= 1'b0;
                        unique case (i_cmd.op)
                            fvesg_pkg::OP_START: r_state <= S_PICK;
                            fvesg_pkg::OP_FRAME: r_state <= S_VOICE;
                            fvesg_pkg::OP_SAMPLE: begin
                                r_state <= S_VOICE;
                                if (i_test_tone) r_tone <= r_tone + fvesg_pkg::ToneStep;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_PICK: begin
                    r_state <= start_ok ? S_DIV : S_FIN;
                    if (start_ok) begin
                        r_ve[pick] <= '{value: r_cmd.vol_byte & 8'hf0,
                            duration: r_cmd.vol_byte & 8'h0f,
                            offset: r_cmd.vol_start, default: 8'd0};
                        r_pe[pick] <= '{value: r_cmd.pit_byte & 8'hf0,
                            duration: r_cmd.pit_byte & 8'h0f,
                            offset: r_cmd.pit_start, default: 8'd0};
                        r_att[pick] <= r_cmd.atten;
                        r_loaded <= 3'(pick);
                        if (pick == '0) begin
                            r_nshift <= 15'h4000;
                            r_nacc <= '0;
                        end
                        r_dv <= pick;
                        r_den <= fvesg_pkg::step_div(r_cmd.pit_byte & 8'hf0);
                        r_quo <= fvesg_pkg::StepK;
                        r_rem <= '0;
                        r_bit <= '0;
                    end
                end
                S_VOICE: begin
                    r_state <= (frame_act && padv) ? S_DIV :
                        voice_last ? S_FIN : S_VOICE;
                    r_vi <= r_vi + 1'b1;
                    if (r_cmd.op == fvesg_pkg::OP_FRAME) begin
                        if (frame_act) begin
                            r_ve[r_vi] <= ve_f;
                            r_pe[r_vi] <= pe_n;
                            if (padv) begin
                                r_dv <= r_vi;
                                r_den <= fvesg_pkg::step_div(pe_n.value);
                                r_quo <= fvesg_pkg::StepK;
                                r_rem <= '0;
                                r_bit <= '0;
                                r_div_go <= !voice_last;
                            end
                        end
                    end else if (r_ve[r_vi].value[7:4] != 4'd0) begin
                        logic signed [9:0] vol;
                        logic signed [9:0] amp;
                        logic hi;
                        logic [7:0] nreg;
                        logic [32:0] sum;
                        logic fb;
                        logic [14:0] sh;
                        vol = 10'(r_ve[r_vi].value) - 10'(r_att[r_vi]);
                        amp = (vol > 0) ? (vol >>> 4) : 10'sd0;
                        if (r_vi == '0) begin
                            nreg = fvesg_pkg::noise_reg_for(r_pe[0].value);
                            sum = {1'b0, r_nacc} + {1'b0, fvesg_pkg::noise_step(nreg[1:0])};
                            r_nacc <= sum[31:0];
                            sh = r_nshift;
                            if (sum[32]) begin
                                fb = nreg[2] ? (sh[0] ^ sh[1]) : sh[0];
                                sh = {fb, sh[14:1]};
                                if (sh == '0) sh = 15'd1;
                            end
                            r_nshift <= sh;
                            hi = sh[0];
                        end else begin
                            hi = r_phase[r_vi][31];
                            r_phase[r_vi] <= r_phase[r_vi] + r_step[r_vi];
                        end
                        r_mix <= hi ? r_mix + amp : r_mix - amp;
                    end
                end
                S_DIV: begin
                    // one quotient bit a cycle
                    r_bit <= r_bit + 6'd1;
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem <= rem_sh - {1'b0, r_den};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    if (r_bit == 6'd63) begin
                        r_state <= r_div_go ? S_VOICE : S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                    o_valid <= 1'b1;
                    o_sample <= (r_cmd.op != fvesg_pkg::OP_SAMPLE) ? 7'sd0 :
                        (r_mix > 10'sd60) ? 7'sd60 :
                        (r_mix < -10'sd60) ? -7'sd60 : 7'(r_mix);
                    o_loaded_voice <= r_loaded;
                    for (int k = 0; k < 4; k++)
                        o_busy_mask[k] <= (k < NUM_VOICES) ?
                            (r_ve[k % NUM_VOICES].duration != 8'd0) : 1'b0;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // divider result write, on its last bit
            if (r_state == S_DIV && r_bit == 6'd63)
                r_step[r_dv] <= (rem_sh >= {1'b0, r_den}) ?
                    {r_quo[30:0], 1'b1} : {r_quo[30:0], 1'b0};
        end
    end
endmodule
